// ===== design/complex_arithmetic_unit_top_defines.svh =====
// Assertion macros used by the checker file of the complex arithmetic unit.
`ifndef COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH
`define COMPLEX_ARITHMETIC_UNIT_TOP_DEFINES_SVH

// Concurrent check on the rising clock edge, switched off while reset is held.
`define CAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check on the rising clock edge that also holds during reset.
`define CAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cau_pkg.sv =====
package cau_pkg;

  // Default number of fraction bits and depth of the queue between the halves.
  localparam int FRAC_BITS_DEF  = 16;
  localparam int FIFO_DEPTH_DEF = 2;

  // Operation codes; unused request codes are folded onto OP_NONE.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAG  = 3'd4;
  localparam logic [2:0] OP_NONE = 3'd7;

  // Result status codes.
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  localparam logic [31:0] SAT_MAX = 32'h7fff_ffff;
  localparam logic [31:0] SAT_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic [1:0]         status;
  } cau_out_t;

  // Classified transaction as it travels from the front end to the back end.
  typedef struct packed {
    logic [2:0]         op;
    logic               dz;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_item_t;

  // One saturated result part with its overflow flag.
  typedef struct packed {
    logic        sat;
    logic [31:0] val;
  } cau_part_t;

  // State of one transaction inside the bit-serial divider and root stages.
  typedef struct packed {
    logic [2:0]  op;
    logic        dz;
    logic        ovf_re;
    logic        ovf_im;
    logic        neg_re;
    logic        neg_im;
    logic [63:0] rem_re;
    logic [63:0] rem_im;
    logic [31:0] lo_re;
    logic [31:0] lo_im;
    logic [31:0] q_re;
    logic [31:0] q_im;
    logic [63:0] den;
    logic [63:0] sv;
    logic [34:0] srem;
    logic [31:0] sroot;
    cau_out_t    pre;
  } cau_lane_t;

  // Saturates a 33-bit two's complement sum into 32 bits.
  function automatic cau_part_t sat_s33(input logic [32:0] x);
    cau_part_t r;
    r.sat = x[32] != x[31];
    if (r.sat) begin
      r.val = x[32] ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = x[31:0];
    end
    return r;
  endfunction

  // Applies a sign to a magnitude and saturates; big marks a magnitude past 32 bits.
  function automatic cau_part_t sat_mag(input logic neg, input logic [31:0] q,
                                        input logic big);
    cau_part_t r;
    r.sat = big || (!neg && q[31]) || (neg && (q > SAT_MIN));
    if (r.sat) begin
      r.val = neg ? SAT_MIN : SAT_MAX;
    end else begin
      r.val = neg ? (~q + 32'd1) : q;
    end
    return r;
  endfunction

endpackage

// ===== design/cau_front.sv =====
module cau_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_item,
  output logic              push,
  output cau_pkg::cau_item_t push_item,
  input  logic              full
);
  import cau_pkg::*;

  logic      vld_r, vld_nxt;
  cau_item_t item_r, item_nxt;
  logic      load;

  assign push      = vld_r && !full;
  assign busy      = vld_r && full;
  assign load      = start && !busy;
  assign push_item = item_r;

  // Classification of the incoming transaction.
  always_comb begin
    item_nxt.a_re = in_item.a_re;
    item_nxt.a_im = in_item.a_im;
    item_nxt.b_re = in_item.b_re;
    item_nxt.b_im = in_item.b_im;
    item_nxt.dz   = (in_item.b_re == 32'sd0) && (in_item.b_im == 32'sd0);
    case (in_item.req_type)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MAG: item_nxt.op = in_item.req_type;
      default:                                item_nxt.op = OP_NONE;
    endcase
  end

  // The holding register empties on a push and refills on an accepted transaction.
  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== design/cau_fifo.sv =====
module cau_fifo #(
  parameter int DEPTH = cau_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  cau_pkg::cau_item_t push_item,
  output logic               full,
  output logic               pop_vld,
  input  logic               pop,
  output cau_pkg::cau_item_t pop_item
);
  import cau_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cau_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = cnt_r == CNT_W'(DEPTH);
  assign pop_vld  = cnt_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && pop_vld;
  assign pop_item = mem_r[rd_ptr_r];

  // Pointer and fill count updates with wrap at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== design/cau_back.sv =====
module cau_back #(
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  input  cau_pkg::cau_item_t in_item,
  output logic               out_vld,
  output cau_pkg::cau_out_t  out_res
);
  import cau_pkg::*;

  localparam int NUM_W = 64 + FRAC_BITS;
  localparam int STEPS = 32;

  // One step of both restoring dividers and of the square root.
  function automatic cau_lane_t lane_step(input cau_lane_t c);
    cau_lane_t   n;
    logic [64:0] tr;
    logic [64:0] ti;
    logic [64:0] dd;
    logic [34:0] sr;
    logic [34:0] st;
    n  = c;
    dd = {1'b0, c.den};
    tr = {c.rem_re, c.lo_re[31]};
    ti = {c.rem_im, c.lo_im[31]};
    if (tr >= dd) begin
      tr       = tr - dd;
      n.q_re   = {c.q_re[30:0], 1'b1};
    end else begin
      n.q_re   = {c.q_re[30:0], 1'b0};
    end
    if (ti >= dd) begin
      ti       = ti - dd;
      n.q_im   = {c.q_im[30:0], 1'b1};
    end else begin
      n.q_im   = {c.q_im[30:0], 1'b0};
    end
    n.rem_re = tr[63:0];
    n.rem_im = ti[63:0];
    n.lo_re  = {c.lo_re[30:0], 1'b0};
    n.lo_im  = {c.lo_im[30:0], 1'b0};
    sr = {c.srem[32:0], c.sv[63:62]};
    st = {1'b0, c.sroot, 2'b01};
    if (sr >= st) begin
      sr      = sr - st;
      n.sroot = {c.sroot[30:0], 1'b1};
    end else begin
      n.sroot = {c.sroot[30:0], 1'b0};
    end
    n.srem = sr;
    n.sv   = {c.sv[61:0], 2'b00};
    return n;
  endfunction

  // Stage one: products and the add or subtract result.
  logic               s1_vld_r;
  logic [2:0]         s1_op_r;
  logic               s1_dz_r;
  logic signed [63:0] p0_r, p1_r, p2_r, p3_r, p4_r, p5_r;
  cau_out_t           s1_pre_r, s1_pre_nxt;
  logic signed [31:0] sq_x, sq_y;
  logic [32:0]        sx, sy;
  cau_part_t          pr, pi;

  always_comb begin
    sq_x = (in_item.op == OP_MAG) ? in_item.a_re : in_item.b_re;
    sq_y = (in_item.op == OP_MAG) ? in_item.a_im : in_item.b_im;
    if (in_item.op == OP_SUB) begin
      sx = {in_item.a_re[31], in_item.a_re} - {in_item.b_re[31], in_item.b_re};
      sy = {in_item.a_im[31], in_item.a_im} - {in_item.b_im[31], in_item.b_im};
    end else begin
      sx = {in_item.a_re[31], in_item.a_re} + {in_item.b_re[31], in_item.b_re};
      sy = {in_item.a_im[31], in_item.a_im} + {in_item.b_im[31], in_item.b_im};
    end
    pr = sat_s33(sx);
    pi = sat_s33(sy);
    case (in_item.op)
      OP_ADD, OP_SUB: begin
        s1_pre_nxt.res_re = pr.val;
        s1_pre_nxt.res_im = pi.val;
        s1_pre_nxt.status = (pr.sat || pi.sat) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        s1_pre_nxt.res_re = '0;
        s1_pre_nxt.res_im = '0;
        s1_pre_nxt.status = ST_DIV0;
      end
      default: begin
        s1_pre_nxt.res_re = '0;
        s1_pre_nxt.res_im = '0;
        s1_pre_nxt.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p0_r     <= in_item.a_re * in_item.b_re;
    p1_r     <= in_item.a_im * in_item.b_im;
    p2_r     <= in_item.a_re * in_item.b_im;
    p3_r     <= in_item.a_im * in_item.b_re;
    p4_r     <= sq_x * sq_x;
    p5_r     <= sq_y * sq_y;
    s1_op_r  <= in_item.op;
    s1_dz_r  <= in_item.dz;
    s1_pre_r <= s1_pre_nxt;
  end

  // Stage two: real and imaginary numerators and the sum of squares.
  logic        s2_vld_r;
  logic [2:0]  s2_op_r;
  logic        s2_dz_r;
  logic [64:0] nre_r, nim_r;
  logic [63:0] sq_r;
  cau_out_t    s2_pre_r;

  always_ff @(posedge clk) begin
    if (s1_op_r == OP_MUL) begin
      nre_r <= {p0_r[63], p0_r} - {p1_r[63], p1_r};
      nim_r <= {p2_r[63], p2_r} + {p3_r[63], p3_r};
    end else begin
      nre_r <= {p0_r[63], p0_r} + {p1_r[63], p1_r};
      nim_r <= {p3_r[63], p3_r} - {p2_r[63], p2_r};
    end
    sq_r     <= $unsigned(p4_r) + $unsigned(p5_r);
    s2_op_r  <= s1_op_r;
    s2_dz_r  <= s1_dz_r;
    s2_pre_r <= s1_pre_r;
  end

  // Stage three: magnitudes, product truncation and divider set-up.
  logic [64:0]      abs_re, abs_im, t_re, t_im;
  logic [NUM_W-1:0] num_re, num_im;
  logic [63:0]      hi_re, hi_im;
  cau_part_t        mr, mi;
  cau_lane_t        ln0;
  cau_lane_t        ln_r [STEPS+1];
  logic [STEPS:0]   ln_vld_r;

  always_comb begin
    abs_re = nre_r[64] ? (~nre_r + 65'd1) : nre_r;
    abs_im = nim_r[64] ? (~nim_r + 65'd1) : nim_r;
    t_re   = abs_re >> FRAC_BITS;
    t_im   = abs_im >> FRAC_BITS;
    mr     = sat_mag(nre_r[64], t_re[31:0], |t_re[64:32]);
    mi     = sat_mag(nim_r[64], t_im[31:0], |t_im[64:32]);
    num_re = NUM_W'(abs_re[63:0]) << FRAC_BITS;
    num_im = NUM_W'(abs_im[63:0]) << FRAC_BITS;
    hi_re  = 64'(num_re[NUM_W-1:32]);
    hi_im  = 64'(num_im[NUM_W-1:32]);

    ln0.op     = s2_op_r;
    ln0.dz     = s2_dz_r;
    ln0.ovf_re = hi_re >= sq_r;
    ln0.ovf_im = hi_im >= sq_r;
    ln0.neg_re = nre_r[64];
    ln0.neg_im = nim_r[64];
    ln0.rem_re = hi_re;
    ln0.rem_im = hi_im;
    ln0.lo_re  = num_re[31:0];
    ln0.lo_im  = num_im[31:0];
    ln0.q_re   = '0;
    ln0.q_im   = '0;
    ln0.den    = sq_r;
    ln0.sv     = sq_r;
    ln0.srem   = '0;
    ln0.sroot  = '0;
    if (s2_op_r == OP_MUL) begin
      ln0.pre.res_re = mr.val;
      ln0.pre.res_im = mi.val;
      ln0.pre.status = (mr.sat || mi.sat) ? ST_SAT : ST_OK;
    end else begin
      ln0.pre = s2_pre_r;
    end
  end

  always_ff @(posedge clk) begin
    ln_r[0] <= ln0;
  end

  // Valid bits of the front stages and of every divider step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      ln_vld_r <= '0;
    end else begin
      s1_vld_r <= in_vld;
      s2_vld_r <= s1_vld_r;
      ln_vld_r <= {ln_vld_r[STEPS-1:0], s2_vld_r};
    end
  end

  // One quotient bit for each of the two dividers and one root bit per stage.
  for (genvar k = 0; k < STEPS; k++) begin : g_step
    always_ff @(posedge clk) begin
      ln_r[k+1] <= lane_step(ln_r[k]);
    end
  end

  // Final selection, sign and saturation.
  cau_lane_t lf;
  cau_part_t dr, di, rt;
  cau_out_t  res_nxt;
  cau_out_t  res_r;
  logic      vld_r;

  always_comb begin
    lf = ln_r[STEPS];
    dr = sat_mag(lf.neg_re, lf.q_re, lf.ovf_re);
    di = sat_mag(lf.neg_im, lf.q_im, lf.ovf_im);
    rt = sat_mag(1'b0, lf.sroot, 1'b0);
    case (lf.op)
      OP_DIV: begin
        if (lf.dz) begin
          res_nxt = lf.pre;
        end else begin
          res_nxt.res_re = dr.val;
          res_nxt.res_im = di.val;
          res_nxt.status = (dr.sat || di.sat) ? ST_SAT : ST_OK;
        end
      end
      OP_MAG: begin
        res_nxt.res_re = rt.val;
        res_nxt.res_im = '0;
        res_nxt.status = rt.sat ? ST_SAT : ST_OK;
      end
      default: res_nxt = lf.pre;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ln_vld_r[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_vld = vld_r;
  assign out_res = res_r;

endmodule

// ===== design/complex_arithmetic_unit_top.sv =====
// Channel   Handshake          Payload                   Direction
// input     start / busy       in_item  (cau_in_t)       in
// result    out_valid strobe   out_item (cau_out_t)      out
//
// An accepted transaction passes the front register, the queue, stages one and two,
// the set-up register, the 32 one-bit divider and root steps and the result register,
// then shows its result for one cycle. The synchronous active-low reset clears the
// valid bits and the queue. The receiver cannot stall: with a queue depth of two or
// more the queue never fills, busy stays low and one transaction is taken every cycle.
module complex_arithmetic_unit_top #(
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
  parameter int FIFO_DEPTH = cau_pkg::FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  cau_pkg::cau_in_t  in_item,
  output logic              out_valid,
  output cau_pkg::cau_out_t out_item
);
  import cau_pkg::*;

  logic      push, full, pop_vld;
  cau_item_t push_item, pop_item;

  // Front end: accepts and classifies transactions.
  cau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .push      (push),
    .push_item (push_item),
    .full      (full)
  );

  // Queue between the two halves.
  cau_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop_vld   (pop_vld),
    .pop       (pop_vld),
    .pop_item  (pop_item)
  );

  // Back end: arithmetic pipeline, drained every cycle.
  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (pop_vld),
    .in_item (pop_item),
    .out_vld (out_valid),
    .out_res (out_item)
  );

endmodule

// ===== design/cau_checker.sv =====
`include "complex_arithmetic_unit_top_defines.svh"

module cau_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input cau_pkg::cau_out_t out_item
);
  import cau_pkg::*;

  // Edges from acceptance to the edge that takes the result.
  localparam int LATENCY = 38;

  logic res_div0, res_zero;

  assign res_div0 = out_valid && (out_item.status == ST_DIV0);
  assign res_zero = (out_item.res_re == 32'sd0) && (out_item.res_im == 32'sd0);

  // A result never carries the unused status code.
  `CAU_ASSERT(a_status_code, out_valid |-> (out_item.status <= ST_SAT), "bad status code")

  // A division by zero always returns a zero result.
  `CAU_ASSERT(a_div0_zero, res_div0 |-> res_zero, "nonzero result on zero divisor")

  // No result strobe follows a reset cycle.
  `CAU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result strobe after reset")

  // The back end drains every cycle, so with a queue depth of two or more the input side is never held off.
  `CAU_ASSERT(a_never_busy, !busy, "busy raised in operation")

  // Every accepted transaction gives its result after the fixed pipeline delay.
  `CAU_ASSERT(a_latency, (start && !busy) |-> ##LATENCY out_valid, "result strobe missing")

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);
